### src/unsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unsf_pkg
// Shared types and constants of the UDP-Notif segmenting framer.
// ----------------------------------------------------------------------------
package unsf_pkg;

    localparam int unsigned PAYLOAD_LENGTH_BITS_DEF = 24;
    localparam int unsigned QUEUE_DEPTH_DEF         = 4;

    // Input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // Encodings
    localparam logic [1:0] ENC_XML  = 2'd2;
    localparam logic [1:0] ENC_CBOR = 2'd3;

    // Media type codes carried in header byte 0
    localparam logic [3:0] MEDIA_JSON = 4'd1;
    localparam logic [3:0] MEDIA_XML  = 4'd2;

    // Result status codes
    localparam logic [2:0] ST_BYTE         = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE    = 3'd1;
    localparam logic [2:0] ST_SEG_SMALL    = 3'd2;
    localparam logic [2:0] ST_TOO_MANY     = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_PUBLISHER_ID = 2'd0;
    localparam logic [1:0] REG_MAX_SEG_SIZE = 2'd1;
    localparam logic [1:0] REG_ENABLE_SEG   = 2'd2;

    // Header constants
    localparam logic [15:0] DEFAULT_MSS   = 16'd1400;
    localparam logic [4:0]  BASE_HDR      = 5'd12;
    localparam logic [4:0]  SEG_HDR       = 5'd16;
    localparam logic [14:0] MAX_SEG_NUM   = 15'h7FFF;
    localparam logic [2:0]  HDR_VERSION   = 3'd1;
    localparam logic [7:0]  OPT_SEG_TYPE  = 8'd1;
    localparam logic [7:0]  OPT_SEG_LEN   = 8'd4;

    // One request for the back end: an error result, or an optional header
    // followed by an optional payload byte.
    typedef struct packed {
        logic [2:0]  status;     // nonzero: single error result
        logic        has_hdr;
        logic        seg;        // header carries the segmentation option
        logic [15:0] mlen;
        logic        hdr_eod;    // header alone closes the datagram
        logic [15:0] opt_word;   // number << 1 | last
        logic [3:0]  media;
        logic [31:0] msg_id;
        logic        has_data;
        logic [7:0]  data;
        logic        data_eod;
    } t_job;

endpackage
`default_nettype wire

### src/unsf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unsf_front
// Accepts input requests, tracks framing state and issues jobs to the queue.
// ----------------------------------------------------------------------------
module unsf_front
    import unsf_pkg::*;
#(
    parameter int unsigned PAYLOAD_LENGTH_BITS = PAYLOAD_LENGTH_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_command,
    input  wire logic [PAYLOAD_LENGTH_BITS-1:0] i_payload_length,
    input  wire logic [1:0]                     i_encoding,
    input  wire logic [7:0]                     i_payload_byte,
    input  wire logic [15:0]                    i_max_segment_size,
    input  wire logic                           i_enable_segmentation,
    output logic                                o_push,
    output t_job                                o_job
);

    localparam int unsigned PLB = PAYLOAD_LENGTH_BITS;
    localparam int unsigned LW  = PLB + 1;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_UNSEG = 2'd1;
    localparam logic [1:0] MODE_SEG   = 2'd2;

    logic [1:0]     r_mode,      n_mode;
    logic [31:0]    r_msg_cnt,   n_msg_cnt;
    logic [31:0]    r_msg_id,    n_msg_id;
    logic [3:0]     r_media,     n_media;
    logic [PLB-1:0] r_bytes_rem, n_bytes_rem;
    logic [15:0]    r_seg_left,  n_seg_left;
    logic [15:0]    r_segnum,    n_segnum;
    logic [15:0]    r_chunk,     n_chunk;

    logic [15:0]    mss;
    logic           fits;
    logic [15:0]    start_chunk;
    logic           start_mode;
    logic [PLB-1:0] sh_rem;
    logic [15:0]    sh_csz;
    logic [15:0]    sh_num;
    logic           sh_last;
    logic [15:0]    sh_chunk;
    logic [15:0]    seg_left_base;
    logic [15:0]    seg_left_dec;
    logic [PLB-1:0] bytes_rem_dec;
    logic           need_hdr;

    assign mss         = (i_max_segment_size == 16'd0) ? DEFAULT_MSS : i_max_segment_size;
    assign fits        = ({1'b0, i_payload_length} + LW'(BASE_HDR)) <= LW'(mss);
    assign start_chunk = mss - 16'(SEG_HDR);
    assign start_mode  = (i_command == CMD_START);
    assign need_hdr    = (r_mode == MODE_SEG) && (r_seg_left == 16'd0);

    // Shared segment header calculation for start and later segments
    assign sh_rem   = start_mode ? i_payload_length : r_bytes_rem;
    assign sh_csz   = start_mode ? start_chunk : r_chunk;
    assign sh_num   = start_mode ? 16'd0 : r_segnum;
    assign sh_last  = sh_rem <= PLB'(sh_csz);
    assign sh_chunk = sh_last ? sh_rem[15:0] : sh_csz;

    assign seg_left_base = need_hdr ? sh_chunk : r_seg_left;
    assign seg_left_dec  = seg_left_base - 16'd1;
    assign bytes_rem_dec = r_bytes_rem - PLB'(1);

    always_comb begin
        n_mode      = r_mode;
        n_msg_cnt   = r_msg_cnt;
        n_msg_id    = r_msg_id;
        n_media     = r_media;
        n_bytes_rem = r_bytes_rem;
        n_seg_left  = r_seg_left;
        n_segnum    = r_segnum;
        n_chunk     = r_chunk;
        o_push      = 1'b0;

        o_job          = '0;
        o_job.media    = r_media;
        o_job.msg_id   = r_msg_id;
        o_job.seg      = 1'b1;
        o_job.mlen     = 16'(SEG_HDR) + sh_chunk;
        o_job.opt_word = {sh_num[14:0] & MAX_SEG_NUM, sh_last};
        o_job.data     = i_payload_byte;

        if (i_accept) begin
            if (start_mode) begin
                o_push = 1'b1;
                n_mode = MODE_IDLE;
                if (i_encoding == ENC_CBOR) begin
                    o_job.status = ST_UNSUPPORTED;
                end else begin
                    n_media     = (i_encoding == ENC_XML) ? MEDIA_XML : MEDIA_JSON;
                    n_msg_id    = r_msg_cnt;
                    n_msg_cnt   = r_msg_cnt + 32'd1;
                    n_bytes_rem = i_payload_length;
                    o_job.media  = n_media;
                    o_job.msg_id = r_msg_cnt;
                    if (fits) begin
                        n_seg_left    = i_payload_length[15:0];
                        o_job.has_hdr = 1'b1;
                        o_job.seg     = 1'b0;
                        o_job.mlen    = i_payload_length[15:0] + 16'(BASE_HDR);
                        o_job.hdr_eod = (i_payload_length == '0);
                        n_mode = (i_payload_length == '0) ? MODE_IDLE : MODE_UNSEG;
                    end else if (!i_enable_segmentation) begin
                        o_job.status = ST_TOO_LARGE;
                    end else if (mss <= 16'(SEG_HDR)) begin
                        o_job.status = ST_SEG_SMALL;
                    end else begin
                        n_chunk       = start_chunk;
                        n_segnum      = 16'd1;
                        n_seg_left    = sh_chunk;
                        n_mode        = MODE_SEG;
                        o_job.has_hdr = 1'b1;
                    end
                end
            end else if (r_mode == MODE_UNSEG || r_mode == MODE_SEG) begin
                o_push = 1'b1;
                if (need_hdr && r_segnum[15]) begin
                    // segment numbers exhausted: drop the rest of the message
                    o_job.status = ST_TOO_MANY;
                    n_mode       = MODE_IDLE;
                end else begin
                    if (need_hdr) begin
                        o_job.has_hdr = 1'b1;
                        n_segnum      = r_segnum + 16'd1;
                    end
                    n_seg_left     = seg_left_dec;
                    n_bytes_rem    = bytes_rem_dec;
                    o_job.has_data = 1'b1;
                    o_job.data_eod = (seg_left_dec == 16'd0);
                    if (bytes_rem_dec == '0) begin
                        n_mode = MODE_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_msg_cnt   <= 32'd1;
            r_msg_id    <= 32'd0;
            r_media     <= 4'd0;
            r_bytes_rem <= '0;
            r_seg_left  <= 16'd0;
            r_segnum    <= 16'd0;
            r_chunk     <= 16'd0;
        end else begin
            r_mode      <= n_mode;
            r_msg_cnt   <= n_msg_cnt;
            r_msg_id    <= n_msg_id;
            r_media     <= n_media;
            r_bytes_rem <= n_bytes_rem;
            r_seg_left  <= n_seg_left;
            r_segnum    <= n_segnum;
            r_chunk     <= n_chunk;
        end
    end

endmodule
`default_nettype wire

### src/unsf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unsf_queue
// Small flop-based job queue between the front and back ends.
// ----------------------------------------------------------------------------
module unsf_queue
    import unsf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty,
    output logic      o_full
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(QUEUE_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_push_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> 1'b0)
        else $error("job pushed into full queue");

endmodule
`default_nettype wire

### src/unsf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unsf_back
// Expands queued jobs into result bytes behind a registered output stage.
// ----------------------------------------------------------------------------
module unsf_back
    import unsf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_job             i_job,
    input  wire logic        i_empty,
    output logic             o_pop,
    input  wire logic [31:0] i_publisher_id,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_status,
    output logic             o_end_of_datagram,
    output logic             o_last
);

    logic       r_valid;
    logic [4:0] r_idx;
    logic [7:0] r_byte;
    logic [2:0] r_status;
    logic       r_eod;
    logic       r_last;

    logic       adv;
    logic       is_err;
    logic [4:0] hdr_len;
    logic [4:0] total;
    logic       is_last;
    logic       in_hdr;
    logic [7:0] hdr_byte;
    logic [7:0] sel_byte;
    logic       sel_eod;

    assign adv     = !i_empty && (!r_valid || i_ready);
    assign is_err  = (i_job.status != ST_BYTE);
    assign hdr_len = !i_job.has_hdr ? 5'd0 : (i_job.seg ? SEG_HDR : BASE_HDR);
    assign total   = hdr_len + {4'd0, i_job.has_data};
    assign is_last = is_err || (r_idx == total - 5'd1);
    assign in_hdr  = r_idx < hdr_len;

    always_comb begin
        case (r_idx[3:0])
            4'd0:    hdr_byte = {HDR_VERSION, 1'b0, i_job.media};
            4'd1:    hdr_byte = {3'd0, hdr_len};
            4'd2:    hdr_byte = i_job.mlen[15:8];
            4'd3:    hdr_byte = i_job.mlen[7:0];
            4'd4:    hdr_byte = i_publisher_id[31:24];
            4'd5:    hdr_byte = i_publisher_id[23:16];
            4'd6:    hdr_byte = i_publisher_id[15:8];
            4'd7:    hdr_byte = i_publisher_id[7:0];
            4'd8:    hdr_byte = i_job.msg_id[31:24];
            4'd9:    hdr_byte = i_job.msg_id[23:16];
            4'd10:   hdr_byte = i_job.msg_id[15:8];
            4'd11:   hdr_byte = i_job.msg_id[7:0];
            4'd12:   hdr_byte = OPT_SEG_TYPE;
            4'd13:   hdr_byte = OPT_SEG_LEN;
            4'd14:   hdr_byte = i_job.opt_word[15:8];
            4'd15:   hdr_byte = i_job.opt_word[7:0];
            default: hdr_byte = 8'd0;
        endcase
    end

    always_comb begin
        if (is_err) begin
            sel_byte = 8'd0;
            sel_eod  = 1'b0;
        end else if (in_hdr) begin
            sel_byte = hdr_byte;
            sel_eod  = i_job.hdr_eod && (r_idx == 5'd11);
        end else begin
            sel_byte = i_job.data;
            sel_eod  = i_job.data_eod;
        end
    end

    assign o_pop = adv && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 5'd0;
        end else if (adv) begin
            r_valid <= 1'b1;
            r_idx   <= is_last ? 5'd0 : r_idx + 5'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_byte   <= sel_byte;
            r_status <= i_job.status;
            r_eod    <= sel_eod;
            r_last   <= is_last;
        end
    end

    assign o_valid           = r_valid;
    assign o_out_byte        = r_byte;
    assign o_status          = r_status;
    assign o_end_of_datagram = r_eod;
    assign o_last            = r_last;

endmodule
`default_nettype wire

### src/udp_notif_segmenting_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udp_notif_segmenting_framer
// Frames notification payloads into UDP-Notif datagrams, with segmentation.
// ----------------------------------------------------------------------------
// Path: a request's job is stored in the job queue, and its results leave
//   through the registered output stage. Throughput: one input request per
//   cycle while the job queue has room, one result per cycle while the sink
//   is ready; a start with a header gives 12 or 16 results, a segment opener 17.
// Reset (synchronous, active low): framing goes idle, the message counter
//   becomes one, registers and queue are cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
module udp_notif_segmenting_framer
    import unsf_pkg::*;
#(
    parameter int unsigned PAYLOAD_LENGTH_BITS = PAYLOAD_LENGTH_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH         = QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // tdata, low bit up: payload_length, encoding, payload_byte, zero fill
    input  wire logic [((PAYLOAD_LENGTH_BITS + 10 + 7) / 8) * 8 - 1:0] i_s_tdata,
    // tuser: command
    input  wire logic              i_s_tuser,
    // result stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // tdata, low bit up: out_byte, last, zero fill
    output logic [15:0]            o_m_tdata,
    // tuser: status
    output logic [2:0]             o_m_tuser,
    // tlast: end_of_datagram
    output logic                   o_m_tlast,
    // configuration write port
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_wdata
);

    localparam int unsigned PLB = PAYLOAD_LENGTH_BITS;

    logic [31:0] r_publisher_id;
    logic [15:0] r_max_seg_size;
    logic        r_enable_seg;

    logic        accept;
    logic        push;
    logic        pop;
    logic        q_empty;
    logic        q_full;
    t_job        push_job;
    t_job        head_job;
    logic [7:0]  out_byte;
    logic        out_last;

    // Configuration registers; the user must write them only while the block is idle, not enforced here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_publisher_id <= 32'd0;
            r_max_seg_size <= 16'd0;
            r_enable_seg   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PUBLISHER_ID: r_publisher_id <= i_cfg_wdata;
                REG_MAX_SEG_SIZE: r_max_seg_size <= i_cfg_wdata[15:0];
                REG_ENABLE_SEG:   r_enable_seg   <= i_cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Take a request whenever the queue can hold the job it may raise
    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    unsf_front #(
        .PAYLOAD_LENGTH_BITS(PAYLOAD_LENGTH_BITS)
    ) u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_accept              (accept),
        .i_command             (i_s_tuser),
        .i_payload_length      (i_s_tdata[PLB-1:0]),
        .i_encoding            (i_s_tdata[PLB+1:PLB]),
        .i_payload_byte        (i_s_tdata[PLB+9:PLB+2]),
        .i_max_segment_size    (r_max_seg_size),
        .i_enable_segmentation (r_enable_seg),
        .o_push                (push),
        .o_job                 (push_job)
    );

    unsf_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Expand jobs into results; header fields read the publisher id live
    unsf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (head_job),
        .i_empty           (q_empty),
        .o_pop             (pop),
        .i_publisher_id    (r_publisher_id),
        .o_valid           (o_m_tvalid),
        .i_ready           (i_m_tready),
        .o_out_byte        (out_byte),
        .o_status          (o_m_tuser),
        .o_end_of_datagram (o_m_tlast),
        .o_last            (out_last)
    );

    assign o_m_tdata = {7'd0, out_last, out_byte};

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_BYTE) |-> (o_m_tdata[8] && !o_m_tlast))
        else $error("error result must end its request and close no datagram");

    a_err_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_BYTE) |-> (o_m_tdata[7:0] == 8'd0))
        else $error("error result carries a nonzero byte");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> !q_empty)
        else $error("input stalled while queue is empty");

endmodule
`default_nettype wire

### sim/tb_udp_notif_segmenting_framer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_udp_notif_segmenting_framer
// Self-checking bench for the UDP-Notif segmenting framer. Start and payload
// requests go in on the input stream. A framing predictor computes every
// expected datagram byte or error result, and each result taken from the
// output stream is compared with the oldest of them. Both stream sides idle
// at random. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb_udp_notif_segmenting_framer;
    import unsf_pkg::*;

    localparam int unsigned RESET_CYCLES     = 11;
    localparam int unsigned SETTLE_CYCLES    = 4;     // result latency plus margin
    localparam int unsigned STALL_LIMIT      = 2000;  // cycles without any handshake
    localparam int unsigned RANDOM_REQUESTS  = 95;
    localparam int unsigned MISMATCH_REPORTS = 10;

    // Encodings that the package leaves unnamed
    localparam logic [1:0] ENC_UNSET = 2'd0;
    localparam logic [1:0] ENC_JSON  = 2'd1;

    // Idle patterns of the two stream sides
    localparam int unsigned GAP_NONE   = 0;
    localparam int unsigned GAP_FULL   = 1;
    localparam int unsigned GAP_BURSTY = 2;

    typedef enum logic [1:0] {
        FRAME_IDLE  = 2'd0,
        FRAME_UNSEG = 2'd1,
        FRAME_SEG   = 2'd2
    } t_frame_mode;

    // One result as seen on the output stream
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] status;
        logic       eod;
        logic       last;
    } t_framer_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // payload_length, encoding, payload_byte, zero fill
    logic        i_s_tuser;   // command
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // out_byte, last, zero fill
    logic [2:0]  o_m_tuser;   // status
    logic        o_m_tlast;   // end_of_datagram
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_wdata;

    udp_notif_segmenting_framer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Framing predictor: shadow registers and framing state
    // ------------------------------------------------------------------------
    logic [31:0] publisher_reg  = '0;
    logic [15:0] seg_size_reg   = '0;
    logic        seg_enable_reg = 1'b0;

    logic [31:0] msg_counter  = 32'd1;
    logic [31:0] msg_id       = '0;
    t_frame_mode frame_mode   = FRAME_IDLE;
    logic [3:0]  media_code   = '0;
    logic [23:0] payload_left = '0;
    logic [15:0] seg_left     = '0;
    logic [15:0] seg_num      = '0;
    logic [15:0] chunk_size   = '0;

    t_framer_byte request_bytes[$];   // results of the request being framed
    t_framer_byte awaited_bytes[$];   // results not yet seen on the output

    int unsigned served_requests = 0; // accepted requests that caused results
    int unsigned mismatch_count  = 0;
    int unsigned stall_cycles    = 0;
    int unsigned src_gap_mode    = GAP_FULL;
    int unsigned sink_gap_mode   = GAP_FULL;

    function automatic void add_byte(logic [7:0] data, logic [2:0] status, logic eod);
        t_framer_byte entry;
        entry.data   = data;
        entry.status = status;
        entry.eod    = eod;
        entry.last   = 1'b0;
        request_bytes.push_back(entry);
    endfunction

    // Error results carry a zero byte and drop the rest of the message
    function automatic void add_error(logic [2:0] status);
        add_byte(8'h00, status, 1'b0);
        frame_mode = FRAME_IDLE;
    endfunction

    function automatic void add_header(logic [7:0] hdr_len, logic [15:0] msg_len, logic closes);
        logic [7:0] hdr [12];
        hdr[0]  = {HDR_VERSION, 1'b0, media_code};
        hdr[1]  = hdr_len;
        hdr[2]  = msg_len[15:8];
        hdr[3]  = msg_len[7:0];
        hdr[4]  = publisher_reg[31:24];
        hdr[5]  = publisher_reg[23:16];
        hdr[6]  = publisher_reg[15:8];
        hdr[7]  = publisher_reg[7:0];
        hdr[8]  = msg_id[31:24];
        hdr[9]  = msg_id[23:16];
        hdr[10] = msg_id[15:8];
        hdr[11] = msg_id[7:0];
        for (int k = 0; k < 12; k++) begin
            add_byte(hdr[k], ST_BYTE, (k == 11) ? closes : 1'b0);
        end
    endfunction

    function automatic void add_segment_header();
        logic [23:0] seg_chunk;
        logic        final_seg;
        logic [15:0] opt_field;
        logic [15:0] msg_len;
        seg_chunk = payload_left;
        final_seg = 1'b1;
        if (payload_left > 24'(chunk_size)) begin
            seg_chunk = 24'(chunk_size);
            final_seg = 1'b0;
        end
        msg_len = 16'(SEG_HDR) + seg_chunk[15:0];
        add_header(8'(SEG_HDR), msg_len, 1'b0);
        opt_field = {seg_num[14:0], final_seg};
        add_byte(OPT_SEG_TYPE, ST_BYTE, 1'b0);
        add_byte(OPT_SEG_LEN, ST_BYTE, 1'b0);
        add_byte(opt_field[15:8], ST_BYTE, 1'b0);
        add_byte(opt_field[7:0], ST_BYTE, 1'b0);
        seg_left = seg_chunk[15:0];
        seg_num  = seg_num + 16'd1;
    endfunction

    // Advance the framing state by one request and queue its results
    function automatic int unsigned frame_request(logic cmd, logic [23:0] len,
                                                  logic [1:0] enc, logic [7:0] data);
        int unsigned mss;
        logic [15:0] msg_len;
        request_bytes.delete();
        if (cmd == CMD_START) begin
            // a start abandons any unfinished message
            frame_mode = FRAME_IDLE;
            if (enc == ENC_CBOR) begin
                add_error(ST_UNSUPPORTED);
            end else begin
                media_code   = (enc == ENC_XML) ? MEDIA_XML : MEDIA_JSON;
                msg_id       = msg_counter;
                msg_counter  = msg_counter + 32'd1;
                mss          = 32'((seg_size_reg == '0) ? DEFAULT_MSS : seg_size_reg);
                payload_left = len;
                if (32'(BASE_HDR) + 32'(len) <= mss) begin
                    seg_left = len[15:0];
                    msg_len  = 16'(BASE_HDR) + len[15:0];
                    add_header(8'(BASE_HDR), msg_len, len == '0);
                    frame_mode = (len == '0) ? FRAME_IDLE : FRAME_UNSEG;
                end else if (!seg_enable_reg) begin
                    add_error(ST_TOO_LARGE);
                end else if (mss <= 32'(SEG_HDR)) begin
                    add_error(ST_SEG_SMALL);
                end else begin
                    chunk_size = 16'(mss - 32'(SEG_HDR));
                    seg_num    = '0;
                    frame_mode = FRAME_SEG;
                    add_segment_header();
                end
            end
        end else if (frame_mode != FRAME_IDLE) begin
            if (frame_mode == FRAME_SEG && seg_left == '0 && seg_num > 16'(MAX_SEG_NUM)) begin
                add_error(ST_TOO_MANY);
            end else begin
                // the header of a later segment goes out just before its first byte
                if (frame_mode == FRAME_SEG && seg_left == '0) begin
                    add_segment_header();
                end
                payload_left = payload_left - 24'd1;
                seg_left     = seg_left - 16'd1;
                add_byte(data, ST_BYTE, seg_left == '0);
                if (payload_left == '0) begin
                    frame_mode = FRAME_IDLE;
                end
            end
        end
        if (request_bytes.size() != 0) begin
            request_bytes[request_bytes.size() - 1].last = 1'b1;
            foreach (request_bytes[k]) begin
                awaited_bytes.push_back(request_bytes[k]);
            end
        end
        return request_bytes.size();
    endfunction

    // ------------------------------------------------------------------------
    // Clock, output side and checking
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_gap(int unsigned mode);
        case (mode)
            GAP_NONE: return 0;
            GAP_FULL: return $urandom_range(0, 17);
            default:  return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
        endcase
    endfunction

    // Result sink: hold ready low for a drawn number of cycles, then take
    // one result. Ready is assigned at most once per edge.
    initial begin : result_sink
        int unsigned gap;
        i_m_tready = 1'b0;
        forever begin
            gap = draw_gap(sink_gap_mode);
            if (gap != 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    // Compare each accepted result with the oldest expected one
    always @(posedge i_clk) begin : result_check
        t_framer_byte want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (awaited_bytes.size() == 0) begin
                if (mismatch_count < MISMATCH_REPORTS) begin
                    $display("%0t: unexpected result byte %02h status %0d eod %b last %b",
                             $realtime, o_m_tdata[7:0], o_m_tuser, o_m_tlast, o_m_tdata[8]);
                end
                mismatch_count = mismatch_count + 1;
            end else begin
                want = awaited_bytes.pop_front();
                if (o_m_tdata[7:0] !== want.data || o_m_tuser !== want.status ||
                    o_m_tlast !== want.eod || o_m_tdata[8] !== want.last) begin
                    if (mismatch_count < MISMATCH_REPORTS) begin
                        $display("%0t: expected byte %02h status %0d eod %b last %b",
                                 $realtime, want.data, want.status, want.eod, want.last);
                        $display("%0t:   actual byte %02h status %0d eod %b last %b",
                                 $realtime, o_m_tdata[7:0], o_m_tuser, o_m_tlast,
                                 o_m_tdata[8]);
                    end
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog: give up when neither stream moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("udp_notif_segmenting_framer test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Send one request. Valid stays high from one request to the next when no
    // gap is drawn, so it is never lowered and raised in the same step.
    task automatic send_request(input logic cmd, input logic [23:0] len,
                                input logic [1:0] enc, input logic [7:0] data);
        int unsigned gap;
        gap = draw_gap(src_gap_mode);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {6'd0, data, enc, len};
        do @(posedge i_clk); while (!o_s_tready);
        if (frame_request(cmd, len, enc, data) != 0) begin
            served_requests = served_requests + 1;
        end
    endtask

    // Unused fields get random values so their input bits toggle
    task automatic send_start(input logic [23:0] len, input logic [1:0] enc);
        send_request(CMD_START, len, enc, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_request(CMD_BYTE, 24'($urandom), 2'($urandom), data);
    endtask

    // Hold requests until every expected result has come, then let the
    // pipeline settle so a request with no result is finished too
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (awaited_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers on consecutive edges while the block is idle
    task automatic apply_settings(input logic [31:0] pub, input logic [15:0] mss,
                                  input logic enable);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_PUBLISHER_ID;
        i_cfg_wdata <= pub;
        @(posedge i_clk);
        i_cfg_index <= REG_MAX_SEG_SIZE;
        i_cfg_wdata <= {16'd0, mss};
        @(posedge i_clk);
        i_cfg_index <= REG_ENABLE_SEG;
        i_cfg_wdata <= {31'd0, enable};
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        publisher_reg  = pub;
        seg_size_reg   = mss;
        seg_enable_reg = enable;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Single datagrams at the default segment size: header-only datagram,
    // byte while idle, surplus byte, abandoned message
    task automatic test_unsegmented_frames();
        apply_settings(32'h0000_0000, 16'd0, 1'b0);
        send_byte(8'hA5);
        send_start(24'd0, ENC_UNSET);
        send_start(24'd3, ENC_JSON);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h3C);
        send_byte(8'h77);
        send_start(24'd2, ENC_XML);
        send_byte(8'h5A);
    endtask

    // Errors and the drop of bytes that follow them, and one message that just fits
    task automatic test_error_drops();
        apply_settings(32'hFFFF_FFFF, 16'd16, 1'b0);
        send_start(24'd5, ENC_CBOR);
        send_byte(8'h11);
        send_start(24'hFF_FFFF, ENC_JSON);
        send_byte(8'h22);
        send_start(24'd4, ENC_XML);
        send_byte(8'h33);
        apply_settings(32'h1234_5678, 16'd16, 1'b1);
        send_start(24'd100, ENC_JSON);
        send_byte(8'h44);
    endtask

    // Segment sizes at their edges: exact fit, size too small to segment, short payload, largest size
    task automatic test_segment_boundaries();
        apply_settings(32'hA5C3_0F96, 16'd12, 1'b1);
        send_start(24'd0, ENC_XML);
        send_start(24'd1, ENC_JSON);
        apply_settings(32'h5A3C_F069, 16'd20, 1'b1);
        send_start(24'd6, ENC_XML);
        repeat (6) send_byte(8'($urandom));
        apply_settings(32'h0F1E_2D3C, 16'hFFFF, 1'b1);
        send_start(24'hFF_FFFF, ENC_JSON);
        send_byte(8'h80);
        send_start(24'd65523, ENC_JSON);
        send_start(24'd65524, ENC_XML);
    endtask

    // Phases of random settings carrying mostly well-formed messages, mixed
    // with stray bytes, cut-short and oversized messages
    task automatic test_random_traffic();
        int unsigned first_count;
        int unsigned n_msgs;
        int unsigned n_bytes;
        logic [23:0] len;
        logic [1:0]  enc;
        logic [15:0] mss;
        first_count = served_requests;
        while (served_requests - first_count < RANDOM_REQUESTS) begin
            case ($urandom_range(0, 6))
                0:       mss = 16'd0;
                1:       mss = 16'd17;
                2:       mss = 16'hFFFF;
                3:       mss = 16'($urandom_range(1, 16));
                4:       mss = 16'($urandom_range(12, 30));
                5:       mss = 16'($urandom);
                default: mss = 16'($urandom_range(17, 64));
            endcase
            apply_settings($urandom, mss, $urandom_range(0, 3) != 0);
            src_gap_mode  = $urandom_range(GAP_NONE, GAP_BURSTY);
            sink_gap_mode = $urandom_range(GAP_NONE, GAP_BURSTY);
            n_msgs = $urandom_range(2, 5);
            for (int m = 0; m < n_msgs; m++) begin
                // hold off until all results are out, once per phase at least
                if (m == 1 || $urandom_range(0, 7) == 0) begin
                    drain_results();
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_byte(8'($urandom));
                end
                enc = ($urandom_range(0, 11) == 0) ? ENC_CBOR : 2'($urandom_range(0, 2));
                if ($urandom_range(0, 7) == 0) begin
                    // huge message, abandoned after a few bytes
                    len     = 24'($urandom);
                    n_bytes = $urandom_range(0, 4);
                end else begin
                    len = 24'($urandom_range(0, 40));
                    case ($urandom_range(0, 9))
                        0:       n_bytes = $urandom_range(0, len);
                        1:       n_bytes = len + $urandom_range(1, 3);
                        default: n_bytes = len;
                    endcase
                end
                send_start(len, enc);
                repeat (n_bytes) send_byte(8'($urandom));
            end
        end
        drain_results();
    endtask

    initial begin : run_tests
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = CMD_START;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_PUBLISHER_ID;
        i_cfg_wdata = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unsegmented_frames();
        test_error_drops();
        test_segment_boundaries();
        test_random_traffic();
        drain_results();

        if (mismatch_count == 0 && awaited_bytes.size() == 0) begin
            $display("udp_notif_segmenting_framer test passed");
        end else begin
            $display("udp_notif_segmenting_framer test failed");
        end
        $finish;
    end

endmodule

### files.f
src/unsf_pkg.sv
src/unsf_front.sv
src/unsf_queue.sv
src/unsf_back.sv
src/udp_notif_segmenting_framer.sv
sim/tb_udp_notif_segmenting_framer.sv
